### sv/cdq_pkg.sv
// Shared types and constants for the circular deque block.
package cdq_pkg;

    localparam int DEPTH_DEF = 16;
    localparam int VALUE_W   = 32;
    localparam int COUNT_W   = 5;

    typedef enum logic [2:0] {
        OP_PUSH_FRONT = 3'd0,
        OP_PUSH_BACK  = 3'd1,
        OP_POP_FRONT  = 3'd2,
        OP_POP_BACK   = 3'd3,
        OP_DELETE     = 3'd4,
        OP_DUMP       = 3'd5
    } cdq_op_t;

    typedef enum logic [1:0] {
        ST_OK        = 2'd0,
        ST_EMPTY     = 2'd1,
        ST_NOT_FOUND = 2'd2,
        ST_FULL      = 2'd3
    } cdq_status_t;

    typedef struct packed {
        cdq_op_t                    operation;
        logic signed [VALUE_W-1:0]  element_value;
    } cdq_req_t;

    typedef struct packed {
        cdq_status_t                status;
        logic signed [VALUE_W-1:0]  out_value;
        logic [COUNT_W-1:0]         out_count;
        logic                       last_result;
    } cdq_rsp_t;

endpackage

### sv/cdq_mem.sv
// Element store: one write port, one read port with registered read data.
module cdq_mem #(
    parameter int DEPTH = cdq_pkg::DEPTH_DEF
) (
    input  logic                            clk,
    input  logic                            we,
    input  logic [$clog2(DEPTH)-1:0]        waddr,
    input  logic [cdq_pkg::VALUE_W-1:0]     wdata,
    input  logic [$clog2(DEPTH)-1:0]        raddr,
    output logic [cdq_pkg::VALUE_W-1:0]     rdata
);
    import cdq_pkg::*;

    logic [VALUE_W-1:0] mem [DEPTH];
    logic [VALUE_W-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    always_ff @(posedge clk)
    begin
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

### sv/cdq_ctrl.sv
// Request sequencer: ring pointers, read-modify-write walk and result register.
module cdq_ctrl #(
    parameter int DEPTH = cdq_pkg::DEPTH_DEF
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            start,
    output logic                            busy,
    input  cdq_pkg::cdq_req_t               request,
    output logic                            done,
    output cdq_pkg::cdq_rsp_t               result,
    output logic                            mem_we,
    output logic [$clog2(DEPTH)-1:0]        mem_waddr,
    output logic [cdq_pkg::VALUE_W-1:0]     mem_wdata,
    output logic [$clog2(DEPTH)-1:0]        mem_raddr,
    input  logic [cdq_pkg::VALUE_W-1:0]     mem_rdata
);
    import cdq_pkg::*;

    localparam int AW = $clog2(DEPTH);
    localparam int CW = $clog2(DEPTH + 1);
    localparam logic [CW:0]   DEPTH_X  = (CW+1)'(DEPTH);
    localparam logic [CW-1:0] FULL_CNT = CW'(DEPTH);
    localparam logic [AW-1:0] LAST_IDX = AW'(DEPTH - 1);

    typedef enum logic [1:0] {
        S_IDLE,
        S_POP,
        S_WALK
    } state_t;

    state_t             state_reg, state_next;
    logic [AW-1:0]      front_reg, front_next;
    logic [CW-1:0]      count_reg, count_next;
    logic               vld_reg, vld_next;
    logic               found_reg, found_next;
    logic               done_reg, done_next;
    cdq_rsp_t           rsp_reg, rsp_next;
    cdq_op_t            op_reg, op_next;
    logic [VALUE_W-1:0] val_reg, val_next;
    logic [VALUE_W-1:0] got_reg, got_next;
    logic [CW-1:0]      rd_off_reg, rd_off_next;
    logic [CW-1:0]      doff_reg, doff_next;

    logic               is_full;
    logic               is_empty;
    logic               walk_last;
    logic [AW-1:0]      front_dec;
    logic [AW-1:0]      front_inc;

    function automatic logic [AW-1:0] ring_pos(input logic [AW-1:0] base,
                                               input logic [CW-1:0] off);
        logic [CW:0] sum;
        sum = (CW+1)'(base) + (CW+1)'(off);
        if (sum >= DEPTH_X)
        begin
            sum = sum - DEPTH_X;
        end
        return sum[AW-1:0];
    endfunction

    function automatic cdq_rsp_t make_rsp(input cdq_status_t st,
                                          input logic [VALUE_W-1:0] value,
                                          input logic last);
        cdq_rsp_t r;
        r.status      = st;
        r.out_value   = value;
        r.out_count   = '0;
        r.last_result = last;
        return r;
    endfunction

    assign is_full   = (count_reg == FULL_CNT);
    assign is_empty  = (count_reg == '0);
    assign walk_last = (CW'(doff_reg + CW'(1)) == count_reg);
    assign front_dec = (front_reg == '0) ? LAST_IDX : front_reg - AW'(1);
    assign front_inc = (front_reg == LAST_IDX) ? '0 : front_reg + AW'(1);

    always_comb
    begin
        state_next  = state_reg;
        front_next  = front_reg;
        count_next  = count_reg;
        vld_next    = 1'b0;
        found_next  = found_reg;
        done_next   = 1'b0;
        rsp_next    = rsp_reg;
        op_next     = op_reg;
        val_next    = val_reg;
        got_next    = got_reg;
        rd_off_next = rd_off_reg;
        doff_next   = doff_reg;
        mem_we      = 1'b0;
        mem_waddr   = front_reg;
        mem_wdata   = request.element_value;
        mem_raddr   = front_reg;

        case (state_reg)
            S_IDLE:
            begin
                if (start)
                begin
                    op_next    = request.operation;
                    val_next   = request.element_value;
                    found_next = 1'b0;
                    case (request.operation)
                        OP_PUSH_FRONT, OP_PUSH_BACK:
                        begin
                            done_next = 1'b1;
                            if (is_full)
                            begin
                                rsp_next = make_rsp(ST_FULL, '0, 1'b1);
                            end
                            else
                            begin
                                mem_we     = 1'b1;
                                count_next = count_reg + CW'(1);
                                rsp_next   = make_rsp(ST_OK, '0, 1'b1);
                                if (request.operation == OP_PUSH_FRONT)
                                begin
                                    mem_waddr  = front_dec;
                                    front_next = front_dec;
                                end
                                else
                                begin
                                    mem_waddr = ring_pos(front_reg, count_reg);
                                end
                            end
                        end
                        OP_POP_FRONT, OP_POP_BACK:
                        begin
                            if (is_empty)
                            begin
                                done_next = 1'b1;
                                rsp_next  = make_rsp(ST_EMPTY, '0, 1'b1);
                            end
                            else
                            begin
                                if (request.operation == OP_POP_BACK)
                                begin
                                    mem_raddr = ring_pos(front_reg, count_reg - CW'(1));
                                end
                                state_next = S_POP;
                            end
                        end
                        OP_DELETE, OP_DUMP:
                        begin
                            if (is_empty)
                            begin
                                done_next = 1'b1;
                                rsp_next  = make_rsp(ST_EMPTY, '0, 1'b1);
                            end
                            else
                            begin
                                // issue the read of the front element now
                                vld_next    = 1'b1;
                                doff_next   = '0;
                                rd_off_next = CW'(1);
                                state_next  = S_WALK;
                            end
                        end
                        default:
                        begin
                            done_next = 1'b1;
                            rsp_next  = make_rsp(ST_OK, '0, 1'b1);
                        end
                    endcase
                end
            end
            S_POP:
            begin
                done_next  = 1'b1;
                rsp_next   = make_rsp(ST_OK, mem_rdata, 1'b1);
                count_next = count_reg - CW'(1);
                if (op_reg == OP_POP_FRONT)
                begin
                    front_next = front_inc;
                end
                state_next = S_IDLE;
            end
            S_WALK:
            begin
                // keep one read in flight ahead of the element being handled
                if (rd_off_reg < count_reg)
                begin
                    mem_raddr   = ring_pos(front_reg, rd_off_reg);
                    vld_next    = 1'b1;
                    doff_next   = rd_off_reg;
                    rd_off_next = rd_off_reg + CW'(1);
                end
                if (vld_reg)
                begin
                    if (op_reg == OP_DUMP)
                    begin
                        done_next = 1'b1;
                        rsp_next  = make_rsp(ST_OK, mem_rdata, walk_last);
                        if (walk_last)
                        begin
                            state_next = S_IDLE;
                        end
                    end
                    else if (found_reg)
                    begin
                        // shift toward the front; writes trail the reads
                        mem_we    = 1'b1;
                        mem_waddr = ring_pos(front_reg, doff_reg - CW'(1));
                        mem_wdata = mem_rdata;
                        if (walk_last)
                        begin
                            count_next = count_reg - CW'(1);
                            done_next  = 1'b1;
                            rsp_next   = make_rsp(ST_OK, got_reg, 1'b1);
                            state_next = S_IDLE;
                        end
                    end
                    else if (mem_rdata == val_reg)
                    begin
                        found_next = 1'b1;
                        got_next   = mem_rdata;
                        if (walk_last)
                        begin
                            count_next = count_reg - CW'(1);
                            done_next  = 1'b1;
                            rsp_next   = make_rsp(ST_OK, mem_rdata, 1'b1);
                            state_next = S_IDLE;
                        end
                    end
                    else if (walk_last)
                    begin
                        done_next  = 1'b1;
                        rsp_next   = make_rsp(ST_NOT_FOUND, '0, 1'b1);
                        state_next = S_IDLE;
                    end
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase

        if (done_next)
        begin
            rsp_next.out_count = COUNT_W'(count_next);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            front_reg <= '0;
            count_reg <= '0;
            vld_reg   <= 1'b0;
            found_reg <= 1'b0;
            done_reg  <= 1'b0;
            rsp_reg   <= '0;
        end
        else
        begin
            state_reg <= state_next;
            front_reg <= front_next;
            count_reg <= count_next;
            vld_reg   <= vld_next;
            found_reg <= found_next;
            done_reg  <= done_next;
            rsp_reg   <= rsp_next;
        end
    end

    always_ff @(posedge clk)
    begin
        op_reg     <= op_next;
        val_reg    <= val_next;
        got_reg    <= got_next;
        rd_off_reg <= rd_off_next;
        doff_reg   <= doff_next;
    end

    assign busy   = (state_reg != S_IDLE);
    assign done   = done_reg;
    assign result = rsp_reg;

endmodule

### sv/circular_deque_with_delete_by_value.sv
// Top level of the bounded double-ended queue with delete by value.
//
// A request is taken at a rising edge with start high and busy low. Its
// results appear one per cycle on result, each marked by done for exactly
// one cycle, and cannot be held off. Pushes, unused operation codes and any
// request that fails as full or empty answer in the next cycle and leave
// busy low, so requests of that kind may follow every cycle. Pops wait in
// S_POP for the registered read data of the element store. Delete by value
// and dump walk the held elements through the single read port, one element
// a cycle; a dump streams its count results on consecutive cycles, count
// being the number of elements held, the final one with last_result set.
// Delete closes the gap by writing each later element one slot toward the
// front while the walk reads ahead. No clearing pass runs after reset: only
// data read from held slots is ever used.
module circular_deque_with_delete_by_value #(
    parameter int DEPTH = cdq_pkg::DEPTH_DEF
) (
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    start,
    output logic                    busy,
    input  cdq_pkg::cdq_req_t       request,
    output logic                    done,
    output cdq_pkg::cdq_rsp_t       result
);
    import cdq_pkg::*;

    localparam int AW = $clog2(DEPTH);

    // store port between sequencer and memory
    logic               mem_we;
    logic [AW-1:0]      mem_waddr;
    logic [VALUE_W-1:0] mem_wdata;
    logic [AW-1:0]      mem_raddr;
    logic [VALUE_W-1:0] mem_rdata;

    // Sequence requests, hold ring pointers, register results.
    cdq_ctrl #(
        .DEPTH (DEPTH)
    ) u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (start),
        .busy      (busy),
        .request   (request),
        .done      (done),
        .result    (result),
        .mem_we    (mem_we),
        .mem_waddr (mem_waddr),
        .mem_wdata (mem_wdata),
        .mem_raddr (mem_raddr),
        .mem_rdata (mem_rdata)
    );

    // Hold the elements.
    cdq_mem #(
        .DEPTH (DEPTH)
    ) u_mem (
        .clk   (clk),
        .we    (mem_we),
        .waddr (mem_waddr),
        .wdata (mem_wdata),
        .raddr (mem_raddr),
        .rdata (mem_rdata)
    );

    // An accepted request either answers next cycle or holds busy.
    a_accept_progress: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy) |=> (done || busy))
        else $error("accepted request neither answered nor went busy");

    // Dump results stream without gaps until the final one.
    a_dump_stream: assert property (@(posedge clk) disable iff (!rst_n)
        (done && !result.last_result) |=> done)
        else $error("gap inside a result stream");

    // The final result of a request frees the block.
    a_last_frees: assert property (@(posedge clk) disable iff (!rst_n)
        (done && result.last_result) |-> !busy)
        else $error("busy after final result");

    // Error statuses always come as a single result.
    a_error_single: assert property (@(posedge clk) disable iff (!rst_n)
        (done && result.status != ST_OK) |-> result.last_result)
        else $error("error result not marked final");

endmodule

### bench/circular_deque_with_delete_by_value_test.sv
// Self-checking bench for the circular deque: directed and random requests against a predictor.
module circular_deque_with_delete_by_value_test;

    import cdq_pkg::*;

    // Ring size of the instance under test (default parameter).
    localparam int SLOTS = DEPTH_DEF;

    // Operation codes the package leaves unnamed; the block must answer them with a plain ok.
    localparam logic [2:0] OP_SPARE_6 = 3'd6;
    localparam logic [2:0] OP_SPARE_7 = 3'd7;

    localparam int RANDOM_ITEMS = 260;
    // Cycles with no request taken before the run is declared hung.
    localparam int QUIET_LIMIT  = 2000;
    // Longest walk is a full delete or dump; allow margin.
    localparam int SETTLE_CYCLES = 2 * SLOTS + 8;

    typedef enum {SEG_FILL, SEG_DRAIN, SEG_MIX} seg_kind_t;

    logic      clk   = 1'b0;
    logic      rst_n = 1'b0;
    logic      start = 1'b0;
    cdq_req_t  request = '0;
    logic      busy;
    logic      done;
    cdq_rsp_t  result;

    always #10 clk = ~clk;

    circular_deque_with_delete_by_value DUT (
        .clk     (clk),
        .rst_n   (rst_n),
        .start   (start),
        .busy    (busy),
        .request (request),
        .done    (done),
        .result  (result)
    );

    // Requests waiting to be launched, and results the predictor says are owed.
    cdq_req_t op_backlog[$];
    cdq_rsp_t due_results[$];

    // Predictor copy of the deque.
    logic signed [VALUE_W-1:0] ring_slot[SLOTS];
    int ring_head = 0;
    int ring_fill = 0;

    // Values reused often so that deletes actually find matches and duplicates occur.
    logic signed [VALUE_W-1:0] value_pool[8];

    int fail_count   = 0;
    int n_sent       = 0;
    int n_checked    = 0;
    int n_full       = 0;
    int n_empty      = 0;
    int n_miss       = 0;
    int gap_left     = 0;
    int calm_stretch = 0;
    int quiet_cycles = 0;
    cdq_rsp_t want;

    // ------------------------------------------------------------------
    // Predictor: apply one accepted request to the shadow deque and queue
    // every result it must produce, in order.
    // ------------------------------------------------------------------
    function automatic int ring_at(input int offset);
        return (ring_head + offset) % SLOTS;
    endfunction

    function automatic void deque_apply(input cdq_req_t req);
        cdq_rsp_t r;
        int k;
        r = '0;
        r.status = ST_OK;
        r.last_result = 1'b1;
        case (req.operation)
            OP_PUSH_FRONT, OP_PUSH_BACK:
            begin
                if (ring_fill == SLOTS)
                begin
                    r.status = ST_FULL;
                    n_full++;
                end
                else
                begin
                    if (req.operation == OP_PUSH_FRONT)
                    begin
                        ring_head = (ring_head + SLOTS - 1) % SLOTS;
                        ring_slot[ring_head] = req.element_value;
                    end
                    else
                        ring_slot[ring_at(ring_fill)] = req.element_value;
                    ring_fill++;
                end
            end
            OP_POP_FRONT, OP_POP_BACK:
            begin
                if (ring_fill == 0)
                begin
                    r.status = ST_EMPTY;
                    n_empty++;
                end
                else
                begin
                    if (req.operation == OP_POP_FRONT)
                    begin
                        r.out_value = ring_slot[ring_head];
                        ring_head = (ring_head + 1) % SLOTS;
                    end
                    else
                        r.out_value = ring_slot[ring_at(ring_fill - 1)];
                    ring_fill--;
                end
            end
            OP_DELETE:
            begin
                if (ring_fill == 0)
                begin
                    r.status = ST_EMPTY;
                    n_empty++;
                end
                else
                begin
                    // Find the first match front to back, on all 32 bits.
                    k = 0;
                    while (k < ring_fill && ring_slot[ring_at(k)] !== req.element_value)
                        k++;
                    if (k == ring_fill)
                    begin
                        r.status = ST_NOT_FOUND;
                        n_miss++;
                    end
                    else
                    begin
                        r.out_value = ring_slot[ring_at(k)];
                        // Close the gap: shift every later element one slot toward the front.
                        while (k + 1 < ring_fill)
                        begin
                            ring_slot[ring_at(k)] = ring_slot[ring_at(k + 1)];
                            k++;
                        end
                        ring_fill--;
                    end
                end
            end
            OP_DUMP:
            begin
                if (ring_fill == 0)
                begin
                    r.status = ST_EMPTY;
                    n_empty++;
                end
                else
                begin
                    // One result per held element, front first; flag the last one.
                    for (k = 0; k < ring_fill; k++)
                    begin
                        r.out_value   = ring_slot[ring_at(k)];
                        r.out_count   = COUNT_W'(ring_fill);
                        r.last_result = (k == ring_fill - 1);
                        due_results.push_back(r);
                    end
                    return;
                end
            end
            default:
            begin
                // Spare codes: no change, single ok result.
            end
        endcase
        r.out_count = COUNT_W'(ring_fill);
        due_results.push_back(r);
    endfunction

    // ------------------------------------------------------------------
    // Stimulus helpers
    // ------------------------------------------------------------------
    function automatic void queue_req(input logic [2:0] op, input logic [31:0] value);
        cdq_req_t q;
        q.operation     = cdq_op_t'(op);
        q.element_value = value;
        op_backlog.push_back(q);
    endfunction

    // Mostly pool values, some one bit off a pool value (near miss), some fully random.
    function automatic logic [31:0] pick_value();
        int roll;
        roll = $urandom_range(0, 99);
        if (roll < 70)
            return value_pool[$urandom_range(0, 7)];
        else if (roll < 80)
            return value_pool[$urandom_range(0, 7)] ^ (32'd1 << $urandom_range(0, 31));
        else
            return $urandom;
    endfunction

    // Draw one random request, weighted by the kind of segment being built.
    function automatic void queue_random_req(input seg_kind_t kind);
        int roll;
        logic [2:0] push_op;
        logic [2:0] pop_op;
        roll    = $urandom_range(0, 99);
        push_op = $urandom_range(0, 1) ? OP_PUSH_FRONT : OP_PUSH_BACK;
        pop_op  = $urandom_range(0, 1) ? OP_POP_FRONT : OP_POP_BACK;
        case (kind)
            SEG_FILL:
            begin
                if (roll < 90)
                    queue_req(push_op, pick_value());
                else if (roll < 95)
                    queue_req(pop_op, $urandom);
                else
                    queue_req(OP_DUMP, $urandom);
            end
            SEG_DRAIN:
            begin
                if (roll < 35)
                    queue_req(pop_op, $urandom);
                else if (roll < 70)
                    queue_req(OP_DELETE, pick_value());
                else if (roll < 80)
                    queue_req(OP_DUMP, $urandom);
                else
                    queue_req(push_op, pick_value());
            end
            default:
            begin
                if (roll < 4)
                    queue_req($urandom_range(0, 1) ? OP_SPARE_6 : OP_SPARE_7, $urandom);
                else if (roll < 35)
                    queue_req(push_op, pick_value());
                else if (roll < 55)
                    queue_req(pop_op, $urandom);
                else if (roll < 82)
                    queue_req(OP_DELETE, pick_value());
                else
                    queue_req(OP_DUMP, $urandom);
            end
        endcase
    endfunction

    // Sender idle gap: usually none, sometimes short, now and then a long one.
    // During a calm stretch launch back to back.
    function automatic int pick_gap();
        int roll;
        if (calm_stretch > 0)
        begin
            calm_stretch--;
            return 0;
        end
        roll = $urandom_range(0, 99);
        if (roll < 3)
        begin
            calm_stretch = $urandom_range(10, 30);
            return 0;
        end
        if (roll < 60)
            return 0;
        if (roll < 90)
            return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    // ------------------------------------------------------------------
    // Driver: a request is taken at an edge with start high and busy low.
    // Predict on acceptance, then hold, idle, or launch the next request
    // with a single assignment to start per edge.
    // ------------------------------------------------------------------
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            start   <= 1'b0;
            request <= '0;
        end
        else
        begin
            if (start && !busy)
            begin
                deque_apply(request);
                n_sent++;
            end
            if (start && busy)
            begin
                // Hold the request until the block takes it.
            end
            else if (gap_left > 0)
            begin
                gap_left--;
                start <= 1'b0;
            end
            else if (op_backlog.size() != 0)
            begin
                request  <= op_backlog.pop_front();
                start    <= 1'b1;
                gap_left = pick_gap();
            end
            else
                start <= 1'b0;
        end
    end

    // ------------------------------------------------------------------
    // Monitor: every done strobe carries one result; compare it field by
    // field with the oldest owed result.
    // ------------------------------------------------------------------
    always @(posedge clk)
    begin
        if (rst_n && done)
        begin
            if (due_results.size() == 0)
            begin
                $error("result with none owed: status %0d out_value %0d out_count %0d",
                       result.status, result.out_value, result.out_count);
                fail_count++;
            end
            else
            begin
                want = due_results.pop_front();
                n_checked++;
                if (result.status !== want.status)
                begin
                    $error("status: expected %0d, got %0d", want.status, result.status);
                    fail_count++;
                end
                if (result.out_value !== want.out_value)
                begin
                    $error("out_value: expected %0d, got %0d", want.out_value, result.out_value);
                    fail_count++;
                end
                if (result.out_count !== want.out_count)
                begin
                    $error("out_count: expected %0d, got %0d", want.out_count, result.out_count);
                    fail_count++;
                end
                if (result.last_result !== want.last_result)
                begin
                    $error("last_result: expected %0d, got %0d",
                           want.last_result, result.last_result);
                    fail_count++;
                end
            end
        end
    end

    // Watchdog: count cycles in which no request is taken.
    always @(posedge clk)
    begin
        if (!rst_n || (start && !busy))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
    end

    // ------------------------------------------------------------------
    // Stimulus and end of run
    // ------------------------------------------------------------------
    initial
    begin
        seg_kind_t seg;
        int seg_len;

        value_pool[0] = 32'h8000_0000;
        value_pool[1] = 32'h7FFF_FFFF;
        value_pool[2] = 32'h0000_0000;
        value_pool[3] = 32'hFFFF_FFFF;
        for (int i = 4; i < 8; i++)
            value_pool[i] = $urandom;

        // Directed: every error path on an empty deque, spare codes.
        queue_req(OP_POP_FRONT, 32'h0);
        queue_req(OP_POP_BACK, 32'hFFFF_FFFF);
        queue_req(OP_DELETE, 32'h5);
        queue_req(OP_DUMP, 32'h0);
        queue_req(OP_SPARE_6, 32'hFFFF_FFFF);
        queue_req(OP_SPARE_7, 32'h0);
        // Extreme values at both ends, a duplicate zero; the front push wraps the ring.
        queue_req(OP_PUSH_BACK, 32'h7FFF_FFFF);
        queue_req(OP_PUSH_FRONT, 32'h8000_0000);
        queue_req(OP_PUSH_BACK, 32'h0);
        queue_req(OP_PUSH_FRONT, 32'hFFFF_FFFF);
        queue_req(OP_PUSH_BACK, 32'h0);
        queue_req(OP_DUMP, 32'h0);
        // Near miss one bit off a held value, then delete the first of two equal values.
        queue_req(OP_DELETE, 32'h7FFF_FFFE);
        queue_req(OP_DELETE, 32'h0);
        queue_req(OP_DUMP, 32'h0);
        queue_req(OP_POP_BACK, 32'h0);
        queue_req(OP_POP_FRONT, 32'h0);
        // Delete at the front, spare code while not empty, delete the last element.
        queue_req(OP_DELETE, 32'h8000_0000);
        queue_req(OP_SPARE_6, 32'h1234_5678);
        queue_req(OP_DELETE, 32'h7FFF_FFFF);
        queue_req(OP_DUMP, 32'h0);

        // Random: segments of fill, drain and mixed traffic; start with a fill
        // so the full status is reached early.
        seg = SEG_FILL;
        while (op_backlog.size() < 21 + RANDOM_ITEMS)
        begin
            seg_len = (seg == SEG_FILL) ? $urandom_range(18, 30) : $urandom_range(10, 30);
            repeat (seg_len)
                queue_random_req(seg);
            seg = seg_kind_t'($urandom_range(0, 2));
        end

        // Hold reset, then release it.
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;

        // Drain: wait until every request is taken and every owed result seen.
        while ((op_backlog.size() != 0 || start || due_results.size() != 0) &&
               quiet_cycles < QUIET_LIMIT)
            @(negedge clk);
        if (quiet_cycles >= QUIET_LIMIT)
        begin
            $error("no progress for %0d cycles, %0d results still owed",
                   QUIET_LIMIT, due_results.size());
            fail_count++;
        end
        else
        begin
            // Let any stray strobe show up before closing.
            repeat (SETTLE_CYCLES) @(negedge clk);
            if (due_results.size() != 0)
            begin
                $error("%0d results never arrived", due_results.size());
                fail_count++;
            end
        end

        $display("covered %0d requests, %0d results checked; full %0d, empty %0d, not found %0d",
                 n_sent, n_checked, n_full, n_empty, n_miss);
        if (fail_count == 0)
            $display("circular_deque_with_delete_by_value_test: done, clean");
        else
            $display("circular_deque_with_delete_by_value_test: done, errors");
        $finish;
    end

endmodule
